>>> hw/rtl/tce_pkg.sv
// tce_pkg: shared types, command codes and sizing constants for the tape
// command executor. No dependencies.
`default_nettype none

package tce_pkg;

    localparam int DEF_TAPE_CELLS  = 32768;
    localparam int DEF_STACK_DEPTH = 64;
    localparam int CODE_POSITIONS  = 65536;
    localparam int POS_W           = $clog2(CODE_POSITIONS);

    localparam logic [3:0] OP_RIGHT = 4'd0;
    localparam logic [3:0] OP_LEFT  = 4'd1;
    localparam logic [3:0] OP_INC   = 4'd2;
    localparam logic [3:0] OP_DEC   = 4'd3;
    localparam logic [3:0] OP_OUT   = 4'd4;
    localparam logic [3:0] OP_IN    = 4'd5;
    localparam logic [3:0] OP_OPEN  = 4'd6;
    localparam logic [3:0] OP_CLOSE = 4'd7;
    localparam logic [3:0] OP_END   = 4'd9;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_UNBAL = 2'd2;
    localparam logic [1:0] ST_OVER  = 2'd3;

    localparam logic [15:0] SKIP_MAX = 16'hFFFF;

    typedef enum logic [3:0] {
        CMD_NOP,
        CMD_RIGHT,
        CMD_LEFT,
        CMD_INC,
        CMD_DEC,
        CMD_OUT,
        CMD_IN,
        CMD_OPEN,
        CMD_CLOSE,
        CMD_END
    } cmd_t;

    typedef struct packed {
        logic [3:0]  operation;
        logic [15:0] position;
        logic [7:0]  input_byte;
    } in_item_t;

    typedef struct packed {
        logic        out_valid;
        logic [7:0]  out_byte;
        logic        jump;
        logic [15:0] resume_position;
        logic [1:0]  status;
    } out_item_t;

    typedef struct packed {
        cmd_t             cmd;
        logic [POS_W-1:0] position;
        logic [7:0]       data;
    } cmd_item_t;

endpackage

`default_nettype wire

>>> hw/rtl/tape_command_executor.sv
// tape_command_executor: top level joining the intake queue and the
// execute stage. Depends on tce_pkg, tce_front, tce_back.
//
// Usage:
//   s_valid/s_ready/s_data carry one command request (operation, code
//   position, input byte). m_valid/m_ready/m_data return exactly one
//   result per request, in order.
//   Result path: a request accepted into an idle block is registered in
//   the queue, then in the execute stage, then in the result register.
//   The execute stage reads tape and loop stack in its issue phase, writes
//   back in its exec phase, and takes no new command until that is done.
//   A two-entry queue lets the input side accept while the execute stage
//   works; the result register lets execution go on while the previous
//   result is still being taken.
//   Reset: clears pointer, stack count, skip depth and error. The tape
//   needs no clearing pass; a fill mark makes never-written cells read as
//   zero, so requests are accepted from the first cycle after reset.
//   Receiver stall: the result register holds, the next command is read
//   and waits in the execute stage, then the queue fills and s_ready drops.
//   Any error is sticky until reset; later requests only report status.
`default_nettype none

module tape_command_executor import tce_pkg::*; #(
    parameter int TAPE_CELLS  = DEF_TAPE_CELLS,
    parameter int STACK_DEPTH = DEF_STACK_DEPTH
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire in_item_t  s_data,
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_item_t      m_data
);

    logic      q_valid;
    logic      q_pop;
    cmd_item_t q_head;

    tce_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_valid (q_valid),
        .q_pop   (q_pop),
        .q_head  (q_head)
    );

    tce_back #(
        .TAPE_CELLS  (TAPE_CELLS),
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_pop   (q_pop),
        .q_head  (q_head),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    a_pop_needs_entry: assert property (
        @(posedge aclk) disable iff (!aresetn) q_pop |-> q_valid
    ) else $error("execute stage popped an empty queue");

    a_error_sticky: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status != ST_OK) |=> (!m_valid || m_data.status != ST_OK)
    ) else $error("error status cleared without reset");

    a_one_kind: assert property (
        @(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_data.jump && m_data.out_valid)
    ) else $error("result carries both output byte and jump");

    a_full_means_pending: assert property (
        @(posedge aclk) disable iff (!aresetn) !s_ready |-> q_valid
    ) else $error("intake stalled with an empty queue");

endmodule

`default_nettype wire

>>> hw/rtl/tce_front.sv
// tce_front: request intake, command decode and a two-entry queue toward
// the execute stage. Depends on tce_pkg.
`default_nettype none

module tce_front import tce_pkg::*; (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire in_item_t  s_data,
    output logic           q_valid,
    input  wire logic      q_pop,
    output cmd_item_t      q_head
);

    localparam logic [1:0] Q_FULL = 2'd2;

    function automatic cmd_t classify(input logic [3:0] op);
        cmd_t c;
        unique case (op)
            OP_RIGHT: c = CMD_RIGHT;
            OP_LEFT:  c = CMD_LEFT;
            OP_INC:   c = CMD_INC;
            OP_DEC:   c = CMD_DEC;
            OP_OUT:   c = CMD_OUT;
            OP_IN:    c = CMD_IN;
            OP_OPEN:  c = CMD_OPEN;
            OP_CLOSE: c = CMD_CLOSE;
            OP_END:   c = CMD_END;
            default:  c = CMD_NOP;
        endcase
        return c;
    endfunction

    cmd_item_t  q_mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push, pop;
    cmd_item_t  item;

    assign s_ready = (cnt_reg != Q_FULL);
    assign q_valid = (cnt_reg != 2'd0);
    assign q_head  = q_mem_reg[rd_ptr_reg];

    assign push = s_valid && s_ready;
    assign pop  = q_pop && q_valid;

    always_comb begin
        item.cmd      = classify(s_data.operation);
        item.position = s_data.position[POS_W-1:0];
        item.data     = s_data.input_byte;
        wr_ptr_next   = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next   = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next      = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem_reg[wr_ptr_reg] <= item;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/tce_back.sv
// tce_back: execute stage holding the tape memory, loop stack memory,
// pointer, skip and error state, and the result register. Depends on tce_pkg.
`default_nettype none

module tce_back import tce_pkg::*; #(
    parameter int TAPE_CELLS  = DEF_TAPE_CELLS,
    parameter int STACK_DEPTH = DEF_STACK_DEPTH
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      q_valid,
    output logic           q_pop,
    input  wire cmd_item_t q_head,
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_item_t      m_data
);

    localparam int PTR_W  = $clog2(TAPE_CELLS);
    localparam int FILL_W = $clog2(TAPE_CELLS + 1);
    localparam int IDX_W  = $clog2(STACK_DEPTH);
    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(TAPE_CELLS - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(STACK_DEPTH);
    localparam logic PH_ISSUE = 1'b0;
    localparam logic PH_EXEC  = 1'b1;

    logic [7:0]       tape_mem  [TAPE_CELLS];
    logic [POS_W-1:0] stack_mem [STACK_DEPTH];

    logic              phase_reg, phase_next;
    logic [PTR_W-1:0]  ptr_reg, ptr_next;
    logic [FILL_W-1:0] fill_reg, fill_next, fill_at;
    logic [CNT_W-1:0]  cnt_reg, cnt_next, cnt_dec;
    logic [15:0]       skip_reg, skip_next;
    logic [1:0]        err_reg, err_next;
    logic              m_valid_reg, m_valid_next;
    out_item_t         m_data_reg, res;

    cmd_item_t         cur_reg;
    logic [7:0]        tape_rd_reg;
    logic [POS_W-1:0]  stack_rd_reg;
    logic              live_reg;

    logic              issue, exec_fire;
    logic              tape_we, stack_we;
    logic [7:0]        tape_wd, cur_cell;
    logic [IDX_W-1:0]  stack_ra, stack_wa;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign issue     = (phase_reg == PH_ISSUE) && q_valid;
    assign exec_fire = (phase_reg == PH_EXEC) && (!m_valid_reg || m_ready);
    assign q_pop     = issue;

    assign cnt_dec  = cnt_reg - CNT_W'(1);
    assign stack_ra = cnt_dec[IDX_W-1:0];
    assign stack_wa = cnt_reg[IDX_W-1:0];
    assign fill_at  = FILL_W'(ptr_reg) + FILL_W'(1);
    // cells at or past the fill mark were never written and read as zero
    assign cur_cell = live_reg ? tape_rd_reg : 8'd0;

    always_comb begin
        phase_next = phase_reg;
        if (issue) begin
            phase_next = PH_EXEC;
        end else if (exec_fire) begin
            phase_next = PH_ISSUE;
        end
    end

    always_comb begin
        ptr_next  = ptr_reg;
        fill_next = fill_reg;
        cnt_next  = cnt_reg;
        skip_next = skip_reg;
        err_next  = err_reg;
        tape_we   = 1'b0;
        tape_wd   = 8'd0;
        stack_we  = 1'b0;
        res       = '0;
        if (exec_fire && (err_reg == ST_OK)) begin
            if (skip_reg != 16'd0) begin
                unique case (cur_reg.cmd)
                    CMD_OPEN: begin
                        if (skip_reg == SKIP_MAX) begin
                            err_next = ST_OVER;
                        end else begin
                            skip_next = skip_reg + 16'd1;
                        end
                    end
                    CMD_CLOSE: skip_next = skip_reg - 16'd1;
                    CMD_END:   err_next  = ST_UNBAL;
                    default: ;
                endcase
            end else begin
                unique case (cur_reg.cmd)
                    CMD_RIGHT: begin
                        if (ptr_reg == PTR_LAST) begin
                            err_next = ST_RANGE;
                        end else begin
                            ptr_next = ptr_reg + PTR_W'(1);
                            // zero-fill the cell being left if it was never written
                            tape_we  = !live_reg;
                        end
                    end
                    CMD_LEFT: begin
                        if (ptr_reg == '0) begin
                            err_next = ST_RANGE;
                        end else begin
                            ptr_next = ptr_reg - PTR_W'(1);
                        end
                    end
                    CMD_INC: begin
                        tape_we = 1'b1;
                        tape_wd = cur_cell + 8'd1;
                    end
                    CMD_DEC: begin
                        tape_we = 1'b1;
                        tape_wd = cur_cell - 8'd1;
                    end
                    CMD_OUT: begin
                        res.out_valid = 1'b1;
                        res.out_byte  = cur_cell;
                    end
                    CMD_IN: begin
                        tape_we = 1'b1;
                        tape_wd = cur_reg.data;
                    end
                    CMD_OPEN: begin
                        if (cur_cell == 8'd0) begin
                            skip_next = 16'd1;
                        end else if (cnt_reg == CNT_FULL) begin
                            err_next = ST_OVER;
                        end else begin
                            stack_we = 1'b1;
                            cnt_next = cnt_reg + CNT_W'(1);
                        end
                    end
                    CMD_CLOSE: begin
                        if (cnt_reg == '0) begin
                            err_next = ST_UNBAL;
                        end else if (cur_cell == 8'd0) begin
                            cnt_next = cnt_dec;
                        end else begin
                            res.jump            = 1'b1;
                            res.resume_position = 16'(stack_rd_reg + POS_W'(1));
                        end
                    end
                    CMD_END: begin
                        if (cnt_reg != '0) begin
                            err_next = ST_UNBAL;
                        end
                    end
                    CMD_NOP: ;
                    default: ;
                endcase
                if (tape_we && !live_reg) begin
                    fill_next = fill_at;
                end
            end
        end
        res.status = err_next;
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (exec_fire) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_ISSUE;
            ptr_reg     <= '0;
            fill_reg    <= '0;
            cnt_reg     <= '0;
            skip_reg    <= 16'd0;
            err_reg     <= ST_OK;
            m_valid_reg <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            ptr_reg     <= ptr_next;
            fill_reg    <= fill_next;
            cnt_reg     <= cnt_next;
            skip_reg    <= skip_next;
            err_reg     <= err_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (issue) begin
            cur_reg  <= q_head;
            live_reg <= (FILL_W'(ptr_reg) < fill_reg);
        end
        if (exec_fire) begin
            m_data_reg <= res;
        end
    end

    always_ff @(posedge aclk) begin
        if (tape_we) begin
            tape_mem[ptr_reg] <= tape_wd;
        end
        if (issue) begin
            tape_rd_reg <= tape_mem[ptr_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (stack_we) begin
            stack_mem[stack_wa] <= cur_reg.position;
        end
        if (issue) begin
            stack_rd_reg <= stack_mem[stack_ra];
        end
    end

endmodule

`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking bench for tape_command_executor. Holds a predictor
// of tape, pointer, loop stack, skip and error state. Depends on tce_pkg.
module tb_top;
    import tce_pkg::*;

    localparam logic [3:0]  OP_NOP         = 4'd8;
    localparam logic [3:0]  OP_SPARE_FIRST = 4'd10;
    localparam logic [3:0]  OP_SPARE_LAST  = 4'd15;
    localparam logic [14:0] TAPE_LAST      = 15'(DEF_TAPE_CELLS - 1);
    localparam int          PTR_SPAN       = 48;
    localparam int          RANDOM_ITEMS   = 900;
    localparam int          CYCLE_LIMIT    = 2_000_000;
    localparam int          DRAIN_CYCLES   = 20;

    typedef enum int {
        FAULT_LEFT_EDGE,
        FAULT_STRAY_CLOSE,
        FAULT_OPEN_AT_END,
        FAULT_SKIP_AT_END,
        FAULT_STACK_FULL
    } fault_kind_t;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_data;

    tape_command_executor DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // predicted block state
    logic [7:0]  tape_img [DEF_TAPE_CELLS];
    logic [14:0] cell_ptr;
    logic [15:0] loop_pos [DEF_STACK_DEPTH];
    int          loop_depth;
    logic [15:0] skip_level;
    logic [1:0]  err_code;

    out_item_t pending_results[$];
    int        fail_count;
    int        cycle_count;
    int        tx_gap_pct;
    int        rx_stall_pct;
    int        stall_left;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic int pick_pct();
        case ($urandom_range(0, 2))
            0: return 0;
            1: return 15;
            default: return 50;
        endcase
    endfunction

    function automatic logic [3:0] noise_op();
        if ($urandom_range(0, 6) == 0) return OP_NOP;
        return 4'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
    endfunction

    function automatic out_item_t predict_result(in_item_t req);
        out_item_t  res;
        logic [7:0] cur_cell;
        res = '0;
        cur_cell = tape_img[cell_ptr];
        if (err_code == ST_OK) begin
            if (skip_level != 0) begin
                case (req.operation)
                    OP_OPEN: begin
                        if (skip_level == SKIP_MAX) err_code = ST_OVER;
                        else skip_level++;
                    end
                    OP_CLOSE: skip_level--;
                    OP_END: err_code = ST_UNBAL;
                    default: ;
                endcase
            end else begin
                case (req.operation)
                    OP_RIGHT: begin
                        if (cell_ptr == TAPE_LAST) err_code = ST_RANGE;
                        else cell_ptr++;
                    end
                    OP_LEFT: begin
                        if (cell_ptr == 0) err_code = ST_RANGE;
                        else cell_ptr--;
                    end
                    OP_INC: tape_img[cell_ptr] = cur_cell + 8'd1;
                    OP_DEC: tape_img[cell_ptr] = cur_cell - 8'd1;
                    OP_OUT: begin
                        res.out_valid = 1'b1;
                        res.out_byte = cur_cell;
                    end
                    OP_IN: tape_img[cell_ptr] = req.input_byte;
                    OP_OPEN: begin
                        if (cur_cell == 0) begin
                            skip_level = 16'd1;
                        end else if (loop_depth == DEF_STACK_DEPTH) begin
                            err_code = ST_OVER;
                        end else begin
                            loop_pos[loop_depth] = req.position;
                            loop_depth++;
                        end
                    end
                    OP_CLOSE: begin
                        if (loop_depth == 0) begin
                            err_code = ST_UNBAL;
                        end else if (cur_cell == 0) begin
                            loop_depth--;
                        end else begin
                            res.jump = 1'b1;
                            res.resume_position = loop_pos[loop_depth - 1] + 16'd1;
                        end
                    end
                    OP_END: begin
                        if (loop_depth != 0) err_code = ST_UNBAL;
                    end
                    default: ;
                endcase
            end
        end
        res.status = err_code;
        return res;
    endfunction

    task automatic send_request(input in_item_t req, output out_item_t res);
        int gap;
        gap = ($urandom_range(0, 99) < tx_gap_pct) ? pick_gap() : 0;
        if (gap > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data <= req;
        do @(posedge aclk); while (!s_ready);
        res = predict_result(req);
        pending_results.push_back(res);
    endtask

    task automatic run_op(input logic [3:0] op, input logic [15:0] pos,
                          input logic [7:0] data);
        in_item_t  req;
        out_item_t res;
        req.operation = op;
        req.position = pos;
        req.input_byte = data;
        send_request(req, res);
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result with no request pending, got %0h", $time, m_data);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("out_valid", 16'(want.out_valid), 16'(m_data.out_valid));
                check_field("out_byte", 16'(want.out_byte), 16'(m_data.out_byte));
                check_field("jump", 16'(want.jump), 16'(m_data.jump));
                check_field("resume_position", want.resume_position,
                            m_data.resume_position);
                check_field("status", 16'(want.status), 16'(m_data.status));
            end
        end
    end

    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left--;
        end else begin
            m_ready <= 1'b1;
            if ($urandom_range(0, 99) < rx_stall_pct) stall_left = pick_gap();
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // wrap on inc/dec, output and input, pointer moves
    task automatic test_cell_ops();
        run_op(OP_OUT, 16'h0000, 8'h00);
        run_op(OP_DEC, 16'h0001, 8'h00);
        run_op(OP_OUT, 16'h0002, 8'h00);
        run_op(OP_INC, 16'h0003, 8'h00);
        run_op(OP_IN, 16'h0004, 8'hFF);
        run_op(OP_INC, 16'h0005, 8'h00);
        run_op(OP_DEC, 16'h0006, 8'h00);
        run_op(OP_OUT, 16'hFFFF, 8'h00);
        run_op(OP_IN, 16'h0008, 8'hA5);
        run_op(OP_RIGHT, 16'h0009, 8'hFF);
        run_op(OP_OUT, 16'h000A, 8'h00);
        run_op(OP_LEFT, 16'h000B, 8'h00);
        run_op(OP_OUT, 16'h000C, 8'h00);
    endtask

    // resume wraps past the top code position; nested push, jump and pop
    task automatic test_loop_brackets();
        run_op(OP_OPEN, 16'hFFFF, 8'h00);
        run_op(OP_CLOSE, 16'h0000, 8'h00);
        run_op(OP_OPEN, 16'h1234, 8'h00);
        run_op(OP_CLOSE, 16'h1236, 8'h00);
        run_op(OP_IN, 16'h1237, 8'h00);
        run_op(OP_CLOSE, 16'h1238, 8'h00);
        run_op(OP_CLOSE, 16'h1239, 8'h00);
        run_op(OP_END, 16'h123A, 8'h00);
    endtask

    // open on a zero cell skips to its matching close; ops in between ignored
    task automatic test_skip_forward();
        run_op(OP_OPEN, 16'h0100, 8'h00);
        run_op(OP_OPEN, 16'h0101, 8'h00);
        run_op(OP_INC, 16'h0102, 8'h00);
        run_op(OP_LEFT, 16'h0103, 8'h00);
        run_op(OP_SPARE_LAST, 16'h0104, 8'hFF);
        run_op(OP_CLOSE, 16'h0105, 8'h00);
        run_op(OP_CLOSE, 16'h0106, 8'h00);
        run_op(OP_OUT, 16'h0107, 8'h00);
        run_op(OP_NOP, 16'h0108, 8'h00);
    endtask

    function automatic in_item_t pick_command();
        in_item_t   c;
        int         r;
        logic [7:0] cur_cell;
        cur_cell = tape_img[cell_ptr];
        c.position = 16'($urandom);
        c.input_byte = 8'($urandom);
        r = $urandom_range(0, 99);
        if (skip_level != 0) begin
            if (r < 40) c.operation = OP_CLOSE;
            else if (r < 55 && skip_level < 8) c.operation = OP_OPEN;
            else if (r < 65) c.operation = noise_op();
            else c.operation = 4'($urandom_range(OP_RIGHT, OP_IN));
            return c;
        end
        if (r < 12) begin
            c.operation = (cell_ptr < PTR_SPAN) ? OP_RIGHT : OP_LEFT;
        end else if (r < 24) begin
            c.operation = (cell_ptr != 0) ? OP_LEFT : OP_RIGHT;
        end else if (r < 36) begin
            c.operation = OP_INC;
        end else if (r < 46) begin
            c.operation = OP_DEC;
        end else if (r < 58) begin
            c.operation = OP_OUT;
        end else if (r < 68) begin
            c.operation = OP_IN;
            if ($urandom_range(0, 9) < 3) c.input_byte = 8'h00;
        end else if (r < 78) begin
            c.operation = OP_OPEN;
            if (cur_cell != 0 && loop_depth == DEF_STACK_DEPTH) begin
                c.operation = OP_IN;
                c.input_byte = 8'h00;
            end
        end else if (r < 93) begin
            if (loop_depth == 0) begin
                c.operation = OP_END;
            end else if (cur_cell != 0 && $urandom_range(0, 2) == 0) begin
                c.operation = OP_IN;
                c.input_byte = 8'h00;
            end else begin
                c.operation = OP_CLOSE;
            end
        end else begin
            c.operation = noise_op();
        end
        return c;
    endfunction

    // host-style run of a counted loop, following each predicted jump
    task automatic run_counted_loop(output int issued);
        logic [3:0]  prog [7];
        logic [15:0] base;
        logic [7:0]  count;
        int          pc;
        in_item_t    req;
        out_item_t   res;
        prog = '{OP_IN, OP_OPEN, OP_RIGHT, OP_INC, OP_LEFT, OP_DEC, OP_CLOSE};
        base = 16'($urandom);
        count = 8'($urandom_range(0, 6));
        issued = 0;
        pc = 0;
        while (pc < 7) begin
            req.operation = prog[pc];
            req.position = base + 16'(pc);
            req.input_byte = count;
            send_request(req, res);
            issued++;
            if (res.jump) pc = int'(16'(res.resume_position - base));
            else pc++;
        end
    endtask

    task automatic test_random_programs();
        int        sent;
        int        chunk_end;
        int        issued;
        in_item_t  req;
        out_item_t res;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            tx_gap_pct = pick_pct();
            rx_stall_pct = pick_pct();
            chunk_end = sent + 150;
            while (sent < chunk_end) begin
                if (skip_level == 0 && loop_depth < DEF_STACK_DEPTH
                        && $urandom_range(0, 99) < 8) begin
                    run_counted_loop(issued);
                    sent += issued;
                end else begin
                    req = pick_command();
                    send_request(req, res);
                    sent++;
                end
            end
            if ($urandom_range(0, 2) == 0) wait_drained();
        end
    endtask

    // close out any open skip and loop, then end of program must pass
    task automatic test_balanced_end();
        while (skip_level != 0) run_op(OP_CLOSE, 16'($urandom), 8'($urandom));
        while (loop_depth != 0) begin
            if (tape_img[cell_ptr] != 0) run_op(OP_IN, 16'($urandom), 8'h00);
            run_op(OP_CLOSE, 16'($urandom), 8'($urandom));
        end
        run_op(OP_END, 16'($urandom), 8'($urandom));
    endtask

    // full loop stack: jump from the top, skip without push, then unwind
    task automatic test_stack_limit();
        run_op(OP_IN, 16'($urandom), 8'($urandom_range(1, 255)));
        while (loop_depth < DEF_STACK_DEPTH) run_op(OP_OPEN, 16'($urandom), 8'($urandom));
        run_op(OP_CLOSE, 16'($urandom), 8'($urandom));
        run_op(OP_IN, 16'($urandom), 8'h00);
        run_op(OP_OPEN, 16'($urandom), 8'($urandom));
        run_op(OP_CLOSE, 16'($urandom), 8'($urandom));
        while (loop_depth != 0) run_op(OP_CLOSE, 16'($urandom), 8'($urandom));
        run_op(OP_END, 16'($urandom), 8'($urandom));
    endtask

    // one error per run (reset is single), then check that it sticks
    task automatic test_sticky_error();
        fault_kind_t kind;
        kind = fault_kind_t'($urandom_range(FAULT_LEFT_EDGE, FAULT_STACK_FULL));
        case (kind)
            FAULT_LEFT_EDGE: begin
                while (cell_ptr != 0) run_op(OP_LEFT, 16'($urandom), 8'($urandom));
                run_op(OP_LEFT, 16'($urandom), 8'($urandom));
            end
            FAULT_STRAY_CLOSE: run_op(OP_CLOSE, 16'($urandom), 8'($urandom));
            FAULT_OPEN_AT_END: begin
                run_op(OP_IN, 16'($urandom), 8'($urandom_range(1, 255)));
                run_op(OP_OPEN, 16'($urandom), 8'($urandom));
                run_op(OP_END, 16'($urandom), 8'($urandom));
            end
            FAULT_SKIP_AT_END: begin
                run_op(OP_IN, 16'($urandom), 8'h00);
                run_op(OP_OPEN, 16'($urandom), 8'($urandom));
                run_op(OP_END, 16'($urandom), 8'($urandom));
            end
            FAULT_STACK_FULL: begin
                run_op(OP_IN, 16'($urandom), 8'($urandom_range(1, 255)));
                while (err_code == ST_OK) run_op(OP_OPEN, 16'($urandom), 8'($urandom));
            end
            default: ;
        endcase
        tx_gap_pct = 30;
        rx_stall_pct = 30;
        repeat (24) run_op(4'($urandom), 16'($urandom), 8'($urandom));
    endtask

    initial begin
        aclk = 1'b0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        m_ready = 1'b0;
        stall_left = 0;
        fail_count = 0;
        cycle_count = 0;
        foreach (tape_img[i]) tape_img[i] = 8'h00;
        foreach (loop_pos[i]) loop_pos[i] = 16'h0000;
        cell_ptr = '0;
        loop_depth = 0;
        skip_level = '0;
        err_code = ST_OK;
        tx_gap_pct = 20;
        rx_stall_pct = 20;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_cell_ops();
        wait_drained();
        test_loop_brackets();
        wait_drained();
        test_skip_forward();
        wait_drained();
        test_random_programs();
        wait_drained();
        tx_gap_pct = 20;
        rx_stall_pct = 20;
        test_balanced_end();
        test_stack_limit();
        wait_drained();
        test_sticky_error();
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
